/* rtl/fcbb_pkg.sv */
`default_nettype none

package fcbb_pkg;

    localparam int MAX_DIM_DEFAULT    = 4096;
    localparam int COUNT_BITS_DEFAULT = 32;

    localparam int CFG_DATA_W  = 32;
    localparam int CFG_INDEX_W = 3;
    localparam int LINE_W      = 12;
    localparam int BOX_W       = 8;
    localparam int CELL_W      = 7;

    localparam logic [CFG_INDEX_W-1:0] REG_START_LINE    = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_INITIAL_COUNT = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_BOX_WIDTH     = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_BOX_HEIGHT    = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] REG_YUV_MODE      = 3'd4;

    localparam logic [LINE_W-1:0] START_LINE_RESET    = 12'd1;
    localparam logic [31:0]       INITIAL_COUNT_RESET = 32'd1;
    localparam logic [BOX_W-1:0]  BOX_WIDTH_RESET     = 8'd30;
    localparam logic [BOX_W-1:0]  BOX_HEIGHT_RESET    = 8'd30;
    localparam logic [BOX_W-1:0]  BOX_WIDTH_MAX       = 8'd128;

    localparam logic [9:0] RGB_ON  = 10'h0ff;
    localparam logic [9:0] RGB_OFF = 10'h000;
    localparam logic [9:0] Y_ON    = 10'h3ac;
    localparam logic [9:0] Y_OFF   = 10'h010;
    localparam logic [9:0] C_MID   = 10'h200;
    localparam logic [7:0] ALPHA_BOX = 8'h00;

    typedef struct packed {
        logic       start_of_frame;
        logic       end_of_line;
        logic       end_of_frame;
        logic [9:0] chan_a;
        logic [9:0] chan_b;
        logic [9:0] chan_c;
        logic [7:0] chan_d;
    } pixel_in_t;

    typedef struct packed {
        logic       out_sof;
        logic       out_eol;
        logic       out_eof;
        logic [9:0] out_a;
        logic [9:0] out_b;
        logic [9:0] out_c;
        logic [7:0] out_d;
    } pixel_out_t;

endpackage

`default_nettype wire

/* rtl/frame_counter_bar_burn_in_unit.sv */
`default_nettype none

// Burns the low COUNT_BITS bits of a frame counter into a pixel stream as a row of boxes,
// most significant bit first, box_width (clamped to 1..128) pixels per box and box_height
// lines starting at start_line; bright boxes for ones, dark for zeros, every other pixel
// unchanged. The counter is loaded by a write of initial_count and advances after each
// end-of-frame beat. One pixel per clock unless m_ready stalls the output: each beat goes
// through one layer of logic into the output register and appears in the cycle after it
// is accepted; s_ready stays high while the output register is empty or being drained.
// The user must write registers only while the stream is idle; the block does not enforce it.
module frame_counter_bar_burn_in_unit
    import fcbb_pkg::*;
#(
    parameter int MAX_DIM    = MAX_DIM_DEFAULT,
    parameter int COUNT_BITS = COUNT_BITS_DEFAULT
) (
    input  wire logic                   aclk,
    input  wire logic                   aresetn,
    input  wire logic                   s_valid,
    output      logic                   s_ready,
    input  wire pixel_in_t              s_data,
    output      logic                   m_valid,
    input  wire logic                   m_ready,
    output      pixel_out_t             m_data,
    input  wire logic                   cfg_wr_en,
    input  wire logic [CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [CFG_DATA_W-1:0]  cfg_wr_data
);

    localparam int ROW_W = $clog2(MAX_DIM);
    localparam int BIT_W = $clog2(COUNT_BITS + 1);
    localparam int CMP_W = ((ROW_W > LINE_W) ? ROW_W : LINE_W) + 1;
    localparam logic [ROW_W-1:0] ROW_MAX  = ROW_W'(MAX_DIM - 1);
    localparam logic [BIT_W-1:0] BIT_END  = BIT_W'(COUNT_BITS);
    localparam logic [BIT_W-1:0] BIT_LAST = BIT_W'(COUNT_BITS - 1);

    logic [LINE_W-1:0]     start_line_reg;
    logic [BOX_W-1:0]      box_width_reg;
    logic [BOX_W-1:0]      box_height_reg;
    logic                  yuv_mode_reg;

    logic [ROW_W-1:0]      row_reg, row_next;
    logic [CELL_W-1:0]     cell_reg, cell_next;
    logic [BIT_W-1:0]      bit_idx_reg, bit_idx_next;
    logic [COUNT_BITS-1:0] count_reg, count_next;

    logic                  m_valid_reg;
    pixel_out_t            m_data_reg, m_data_next;

    logic                  s_accept;
    logic [ROW_W-1:0]      row_cur;
    logic [CELL_W-1:0]     cell_cur;
    logic [BIT_W-1:0]      bit_cur;
    logic [BOX_W-1:0]      width_eff;
    logic [CMP_W-1:0]      row_ext, line_ext, row_diff;
    logic                  in_rows, in_box, bit_one;
    logic [BIT_W-1:0]      shift_amt;
    logic [COUNT_BITS-1:0] count_shifted;
    logic [BOX_W-1:0]      cell_inc;

    assign s_ready  = !m_valid_reg || m_ready;
    assign s_accept = s_valid && s_ready;
    assign m_valid  = m_valid_reg;
    assign m_data   = m_data_reg;

    always_comb begin
        if (box_width_reg == '0) begin
            width_eff = BOX_W'(1);
        end else if (box_width_reg > BOX_WIDTH_MAX) begin
            width_eff = BOX_WIDTH_MAX;
        end else begin
            width_eff = box_width_reg;
        end

        row_cur  = s_data.start_of_frame ? '0 : row_reg;
        cell_cur = s_data.start_of_frame ? '0 : cell_reg;
        bit_cur  = s_data.start_of_frame ? '0 : bit_idx_reg;

        row_ext  = CMP_W'(row_cur);
        line_ext = CMP_W'(start_line_reg);
        row_diff = row_ext - line_ext;
        in_rows  = (row_ext >= line_ext) && (row_diff < CMP_W'(box_height_reg));
        in_box   = in_rows && (bit_cur < BIT_END);

        shift_amt     = BIT_LAST - bit_cur;
        count_shifted = count_reg >> shift_amt;
        bit_one       = count_shifted[0];

        m_data_next.out_sof = s_data.start_of_frame;
        m_data_next.out_eol = s_data.end_of_line;
        m_data_next.out_eof = s_data.end_of_frame;
        m_data_next.out_a   = s_data.chan_a;
        m_data_next.out_b   = s_data.chan_b;
        m_data_next.out_c   = s_data.chan_c;
        m_data_next.out_d   = s_data.chan_d;
        if (in_box) begin
            if (yuv_mode_reg) begin
                m_data_next.out_a = bit_one ? Y_ON : Y_OFF;
                m_data_next.out_b = C_MID;
                m_data_next.out_c = C_MID;
            end else begin
                m_data_next.out_a = bit_one ? RGB_ON : RGB_OFF;
                m_data_next.out_b = bit_one ? RGB_ON : RGB_OFF;
                m_data_next.out_c = bit_one ? RGB_ON : RGB_OFF;
                m_data_next.out_d = ALPHA_BOX;
            end
        end

        cell_inc     = BOX_W'(cell_cur) + BOX_W'(1);
        row_next     = row_cur;
        cell_next    = cell_cur;
        bit_idx_next = bit_cur;
        count_next   = count_reg;
        if (s_data.end_of_frame) begin
            row_next     = '0;
            cell_next    = '0;
            bit_idx_next = '0;
            count_next   = count_reg + COUNT_BITS'(1);
        end else if (s_data.end_of_line) begin
            if (row_cur < ROW_MAX) begin
                row_next = row_cur + ROW_W'(1);
            end
            cell_next    = '0;
            bit_idx_next = '0;
        end else if (cell_inc >= width_eff) begin
            cell_next = '0;
            if (bit_cur < BIT_END) begin
                bit_idx_next = bit_cur + BIT_W'(1);
            end
        end else begin
            cell_next = cell_inc[CELL_W-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            start_line_reg <= START_LINE_RESET;
            box_width_reg  <= BOX_WIDTH_RESET;
            box_height_reg <= BOX_HEIGHT_RESET;
            yuv_mode_reg   <= 1'b0;
            row_reg        <= '0;
            cell_reg       <= '0;
            bit_idx_reg    <= '0;
            count_reg      <= INITIAL_COUNT_RESET[COUNT_BITS-1:0];
            m_valid_reg    <= 1'b0;
        end else begin
            if (s_accept) begin
                row_reg     <= row_next;
                cell_reg    <= cell_next;
                bit_idx_reg <= bit_idx_next;
                count_reg   <= count_next;
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
            if (cfg_wr_en) begin
                case (cfg_index)
                    REG_START_LINE:    start_line_reg <= cfg_wr_data[LINE_W-1:0];
                    REG_INITIAL_COUNT: count_reg      <= cfg_wr_data[COUNT_BITS-1:0];
                    REG_BOX_WIDTH:     box_width_reg  <= cfg_wr_data[BOX_W-1:0];
                    REG_BOX_HEIGHT:    box_height_reg <= cfg_wr_data[BOX_W-1:0];
                    REG_YUV_MODE:      yuv_mode_reg   <= cfg_wr_data[0];
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            m_data_reg <= m_data_next;
        end
    end

    a_bit_idx_range: assert property (@(posedge aclk) disable iff (!aresetn)
        bit_idx_reg <= BIT_END)
        else $error("bit index past last box");

    a_eof_homes: assert property (@(posedge aclk) disable iff (!aresetn)
        s_accept && s_data.end_of_frame |=> row_reg == '0 && bit_idx_reg == '0 && cell_reg == '0)
        else $error("position not homed after end of frame");

    a_eof_count: assert property (@(posedge aclk) disable iff (!aresetn)
        s_accept && s_data.end_of_frame && !cfg_wr_en
        |=> count_reg == $past(count_reg) + COUNT_BITS'(1))
        else $error("frame count did not advance");

    a_rgb_alpha: assert property (@(posedge aclk) disable iff (!aresetn)
        s_accept && in_box && !yuv_mode_reg |=> m_valid && m_data.out_d == ALPHA_BOX)
        else $error("alpha not cleared inside box");

    a_pass_through: assert property (@(posedge aclk) disable iff (!aresetn)
        s_accept && !in_box |=> m_data.out_a == $past(s_data.chan_a)
                                && m_data.out_d == $past(s_data.chan_d))
        else $error("pixel outside box altered");

endmodule

`default_nettype wire
